[hdl/smr_pkg.sv]
`timescale 1ns / 1ps

package smr_pkg;

   localparam int DEF_SEGMENT_SLOTS     = 64;
   localparam int DEF_WORDS_PER_SEGMENT = 256;

   // request fields
   localparam int MODE_W    = 3;
   localparam int SID_W     = 6;
   localparam int OFF_W     = 8;
   localparam int WORD_W    = 32;
   localparam int MLEN_W    = 9;
   localparam int MODE_LSB  = 0;
   localparam int SID_LSB   = MODE_LSB + MODE_W;
   localparam int OFF_LSB   = SID_LSB + SID_W;
   localparam int VAL_LSB   = OFF_LSB + OFF_W;
   localparam int MLEN_LSB  = VAL_LSB + WORD_W;
   localparam int REQ_USED  = MLEN_LSB + MLEN_W;
   localparam int REQ_TDATA_W = ((REQ_USED + 7) / 8) * 8;

   // response fields
   localparam int STATUS_W   = 3;
   localparam int GID_W      = 6;
   localparam int STATUS_LSB = 0;
   localparam int DATA_LSB   = STATUS_LSB + STATUS_W;
   localparam int GID_LSB    = DATA_LSB + WORD_W;
   localparam int RSP_USED   = GID_LSB + GID_W;
   localparam int RSP_TDATA_W = ((RSP_USED + 7) / 8) * 8;

   localparam int CSR_W = 9;

   localparam logic [MODE_W-1:0] MODE_MAP    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UNMAP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STORE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd4;
   localparam logic [MODE_W-1:0] MODE_LENGTH = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_OFF  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_ID    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 3'd4;

   typedef struct packed {
      logic capture;
      logic eval;
      logic load_capture;
      logic fill_step;
      logic cfg_start;
      logic publish;
   } smr_cmd_type;

   typedef struct packed {
      logic load_go;
      logic fill_go;
      logic fill_busy;
      logic out_free;
   } smr_stat_type;

endpackage

[hdl/smr_ram.sv]
`timescale 1ns / 1ps

module smr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/smr_ctrl.sv]
`timescale 1ns / 1ps

module smr_ctrl
   import smr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         csr_we,
   input  smr_stat_type stat,
   output smr_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_FILL = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       fill_item_ff, fill_item_in;

   assign req_tready = (state_ff == ST_IDLE) && !csr_we;

   always_comb begin
      state_in     = state_ff;
      fill_item_in = fill_item_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               cmd.cfg_start = 1'b1;
               fill_item_in  = 1'b0;
               state_in      = ST_FILL;
            end else if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (stat.load_go) begin
               state_in = ST_LOAD;
            end else if (stat.fill_go) begin
               fill_item_in = 1'b1;
               state_in     = ST_FILL;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_LOAD: begin
            cmd.load_capture = 1'b1;
            state_in         = ST_RESP;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (!stat.fill_busy) begin
               state_in = fill_item_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_RESP: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_item_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_item_ff <= fill_item_in;
      end
   end

endmodule

[hdl/smr_datapath.sv]
`timescale 1ns / 1ps

module smr_datapath
   import smr_pkg::*;
#(
   parameter int SEGMENT_SLOTS     = DEF_SEGMENT_SLOTS,
   parameter int WORDS_PER_SEGMENT = DEF_WORDS_PER_SEGMENT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_we,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  smr_cmd_type            cmd,
   output smr_stat_type           stat,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDW    = $clog2(SEGMENT_SLOTS);
   localparam int CW     = IDW + 1;
   localparam int LW     = $clog2(WORDS_PER_SEGMENT + 1);
   localparam int TW     = LW + 1;
   localparam int WDEPTH = SEGMENT_SLOTS * WORDS_PER_SEGMENT;
   localparam int AW     = $clog2(WDEPTH);

   // captured request
   logic [MODE_W-1:0] mode_ff;
   logic [SID_W-1:0]  sid_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [WORD_W-1:0] val_ff;
   logic [MLEN_W-1:0] mlen_ff;
   logic [AW-1:0]     base_ff, base_in;

   logic          seg0_mapped_ff, seg0_mapped_in;
   logic [LW-1:0] seg0_len_ff, seg0_len_in;
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [LW-1:0] fill_ptr_ff, fill_ptr_in;
   logic [LW-1:0] fill_end_ff, fill_end_in;
   logic [AW-1:0] fill_base_ff, fill_base_in;

   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic [WORD_W-1:0]   pend_data_ff, pend_data_in;
   logic [GID_W-1:0]    pend_gid_ff, pend_gid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [WORD_W-1:0]   rsp_data_ff;
   logic [GID_W-1:0]    rsp_gid_ff;

   // memory ports
   logic           tbl_we;
   logic [IDW-1:0] tbl_waddr;
   logic [TW-1:0]  tbl_wdata, tbl_rdata;
   logic           stk_we;
   logic [IDW-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
   logic           w_we, w_re;
   logic [AW-1:0]  w_addr;
   logic [WORD_W-1:0] w_wdata, w_rdata;

   logic [IDW-1:0] in_sid_idx;
   logic [IDW-1:0] sid_idx, new_id;
   logic           sid_in_range, sid_zero, below_fresh, seg_mapped;
   logic [LW-1:0]  seg_len, cfg_len;
   logic           map_too_long, have_free, have_fresh, off_bad, seg_full, fill_busy;

   assign in_sid_idx = IDW'(req_tdata[SID_LSB +: SID_W]);
   assign base_in    = AW'(in_sid_idx) * AW'(WORDS_PER_SEGMENT);
   assign stk_raddr  = IDW'(free_cnt_ff - CW'(1));

   assign sid_idx      = IDW'(sid_ff);
   assign sid_in_range = 32'(sid_ff) < 32'(SEGMENT_SLOTS);
   assign sid_zero     = (sid_ff == '0);
   assign below_fresh  = CW'(sid_idx) < fresh_ff;
   assign seg_mapped   = sid_in_range &&
                         (sid_zero ? seg0_mapped_ff : (below_fresh && tbl_rdata[LW]));
   assign seg_len      = sid_zero ? seg0_len_ff : tbl_rdata[LW-1:0];
   assign map_too_long = 32'(mlen_ff) > 32'(WORDS_PER_SEGMENT);
   assign have_free    = (free_cnt_ff != '0);
   assign have_fresh   = fresh_ff < CW'(SEGMENT_SLOTS);
   assign new_id       = have_free ? stk_rdata : fresh_ff[IDW-1:0];
   assign off_bad      = 32'(off_ff) >= 32'(seg_len);
   assign seg_full     = 32'(seg_len) >= 32'(WORDS_PER_SEGMENT);
   assign fill_busy    = fill_ptr_ff < fill_end_ff;
   assign cfg_len      = (32'(csr_wdata) > 32'(WORDS_PER_SEGMENT)) ?
                         LW'(WORDS_PER_SEGMENT) : LW'(csr_wdata);

   always_comb begin
      seg0_mapped_in = seg0_mapped_ff;
      seg0_len_in    = seg0_len_ff;
      free_cnt_in    = free_cnt_ff;
      fresh_in       = fresh_ff;
      fill_ptr_in    = fill_ptr_ff;
      fill_end_in    = fill_end_ff;
      fill_base_in   = fill_base_ff;
      pend_status_in = pend_status_ff;
      pend_data_in   = pend_data_ff;
      pend_gid_in    = pend_gid_ff;
      tbl_we         = 1'b0;
      tbl_waddr      = sid_idx;
      tbl_wdata      = '0;
      stk_we         = 1'b0;
      stk_waddr      = free_cnt_ff[IDW-1:0];
      stk_wdata      = sid_idx;
      w_we           = 1'b0;
      w_re           = 1'b0;
      w_addr         = base_ff + AW'(off_ff);
      w_wdata        = val_ff;
      stat           = '0;
      stat.fill_busy = fill_busy;
      stat.out_free  = !rsp_valid_ff || rsp_tready;

      if (cmd.eval) begin
         pend_status_in = STATUS_OK;
         pend_data_in   = '0;
         pend_gid_in    = '0;
         case (mode_ff)
            MODE_MAP: begin
               if (map_too_long) begin
                  pend_status_in = STATUS_CAPACITY;
               end else if (!have_free && !have_fresh) begin
                  pend_status_in = STATUS_NO_ID;
               end else begin
                  if (have_free) begin
                     free_cnt_in = free_cnt_ff - CW'(1);
                  end else begin
                     fresh_in = fresh_ff + CW'(1);
                  end
                  tbl_we    = 1'b1;
                  tbl_waddr = new_id;
                  tbl_wdata = {1'b1, LW'(mlen_ff)};
                  if (new_id == '0) begin
                     seg0_mapped_in = 1'b1;
                     seg0_len_in    = LW'(mlen_ff);
                  end
                  pend_gid_in  = GID_W'(new_id);
                  fill_base_in = AW'(new_id) * AW'(WORDS_PER_SEGMENT);
                  fill_ptr_in  = '0;
                  fill_end_in  = LW'(mlen_ff);
                  stat.fill_go = 1'b1;
               end
            end
            MODE_UNMAP: begin
               if (!seg_mapped) begin
                  pend_status_in = STATUS_UNMAPPED;
               end else begin
                  tbl_we = 1'b1;
                  if (sid_zero) begin
                     seg0_mapped_in = 1'b0;
                     seg0_len_in    = '0;
                  end
                  if (free_cnt_ff < CW'(SEGMENT_SLOTS)) begin
                     stk_we      = 1'b1;
                     free_cnt_in = free_cnt_ff + CW'(1);
                  end
               end
            end
            MODE_LOAD, MODE_STORE: begin
               if (!seg_mapped) begin
                  pend_status_in = STATUS_UNMAPPED;
               end else if (off_bad) begin
                  pend_status_in = STATUS_BAD_OFF;
               end else if (mode_ff == MODE_LOAD) begin
                  w_re         = 1'b1;
                  stat.load_go = 1'b1;
               end else begin
                  w_we = 1'b1;
               end
            end
            MODE_APPEND: begin
               if (!seg_mapped) begin
                  pend_status_in = STATUS_UNMAPPED;
               end else if (seg_full) begin
                  pend_status_in = STATUS_CAPACITY;
               end else begin
                  w_we      = 1'b1;
                  w_addr    = base_ff + AW'(seg_len);
                  tbl_we    = 1'b1;
                  tbl_wdata = {1'b1, seg_len + LW'(1)};
                  if (sid_zero) begin
                     seg0_len_in = seg_len + LW'(1);
                  end
               end
            end
            MODE_LENGTH: begin
               if (!seg_mapped) begin
                  pend_status_in = STATUS_UNMAPPED;
               end else begin
                  pend_data_in = WORD_W'(seg_len);
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.fill_step && fill_busy) begin
         w_we        = 1'b1;
         w_addr      = fill_base_ff + AW'(fill_ptr_ff);
         w_wdata     = '0;
         fill_ptr_in = fill_ptr_ff + LW'(1);
      end

      if (cmd.load_capture) begin
         pend_data_in = w_rdata;
      end

      // segment 0 resize; growth zeroes the newly exposed words
      if (csr_we && seg0_mapped_ff) begin
         seg0_len_in = cfg_len;
         fill_end_in = cfg_len;
      end
      if (cmd.cfg_start) begin
         fill_ptr_in  = seg0_len_ff;
         fill_base_in = '0;
         fill_end_in  = seg0_mapped_ff ? cfg_len : '0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg0_mapped_ff <= 1'b1;
         seg0_len_ff    <= '0;
         free_cnt_ff    <= '0;
         fresh_ff       <= CW'(1);
         fill_ptr_ff    <= '0;
         fill_end_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seg0_mapped_ff <= seg0_mapped_in;
         seg0_len_ff    <= seg0_len_in;
         free_cnt_ff    <= free_cnt_in;
         fresh_ff       <= fresh_in;
         fill_ptr_ff    <= fill_ptr_in;
         fill_end_ff    <= fill_end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_tdata[MODE_LSB +: MODE_W];
         sid_ff  <= req_tdata[SID_LSB +: SID_W];
         off_ff  <= req_tdata[OFF_LSB +: OFF_W];
         val_ff  <= req_tdata[VAL_LSB +: WORD_W];
         mlen_ff <= req_tdata[MLEN_LSB +: MLEN_W];
         base_ff <= base_in;
      end
      fill_base_ff   <= fill_base_in;
      pend_status_ff <= pend_status_in;
      pend_data_ff   <= pend_data_in;
      pend_gid_ff    <= pend_gid_in;
      if (cmd.publish) begin
         rsp_status_ff <= pend_status_ff;
         rsp_data_ff   <= pend_data_ff;
         rsp_gid_ff    <= pend_gid_ff;
      end
   end

   smr_ram #(.WIDTH(TW), .DEPTH(SEGMENT_SLOTS)) u_seg_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (in_sid_idx),
      .rd_data (tbl_rdata)
   );

   smr_ram #(.WIDTH(IDW), .DEPTH(SEGMENT_SLOTS)) u_free_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   smr_ram #(.WIDTH(WORD_W), .DEPTH(WDEPTH)) u_word_store (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_addr),
      .wr_data (w_wdata),
      .rd_en   (w_re),
      .rd_addr (w_addr),
      .rd_data (w_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED)'(0), rsp_gid_ff, rsp_data_ff, rsp_status_ff};

endmodule

[hdl/segmented_memory_with_id_recycling.sv]
`timescale 1ns / 1ps

// Segmented word memory with LIFO id recycling. One request per transfer on
// req_, one result per request on rsp_. Requests are handled one at a time:
// each is captured, evaluated and published once the output register is
// free; load adds a capture of the read data (one read of the single-port
// word memory), and map of n words adds a zero-fill that writes one word per
// cycle through that same port. A csr_ write holds off requests in its own
// cycle and while the fill state then runs, which zero-fills the new words
// when it grows segment 0. No clearing pass runs after reset. A finished
// result waits in the output register while the next request is accepted.
module segmented_memory_with_id_recycling
   import smr_pkg::*;
#(
   parameter int SEGMENT_SLOTS     = DEF_SEGMENT_SLOTS,
   parameter int WORDS_PER_SEGMENT = DEF_WORDS_PER_SEGMENT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // mode, segment_id, word_offset, write_value, map_length
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status, read_data, granted_id
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_W-1:0]       csr_wdata
);

   smr_cmd_type  cmd;
   smr_stat_type stat;

   smr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_we     (csr_we),
      .stat       (stat),
      .cmd        (cmd)
   );

   smr_datapath #(
      .SEGMENT_SLOTS     (SEGMENT_SLOTS),
      .WORDS_PER_SEGMENT (WORDS_PER_SEGMENT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.eval)
      else $error("accepted request not evaluated");

   a_load_capture: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && stat.load_go) |=> cmd.load_capture)
      else $error("load data not captured");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[STATUS_LSB +: STATUS_W] != STATUS_OK) |->
      (rsp_tdata[DATA_LSB +: WORD_W] == '0 && rsp_tdata[GID_LSB +: GID_W] == '0))
      else $error("error result carries data");
`endif

endmodule
